### hw/rtl/differential_drive_odometry_top_macros.svh
// Assertion macros shared by the odometry RTL.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_TOP_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_TOP_MACROS_SVH

// Same-cycle implication, checked on clk and disabled during reset.
`define DDO_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled during reset.
`define DDO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ddo_pkg.sv
package ddo_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 24;

  // Angles in units of 2^-28 rad.
  localparam logic [31:0] ANG_PI      = 32'd843314857;
  localparam logic [31:0] ANG_TWO_PI  = 32'd1686629713;
  localparam logic [31:0] ANG_HALF_PI = 32'd421657428;
  localparam logic [31:0] CORDIC_GAIN = 32'd163008219;

  // Register indexes, decoded from paddr[2].
  localparam logic REG_WHEEL_BASE = 1'b0;
  localparam logic REG_THRESHOLD  = 1'b1;

  typedef struct packed {
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } trig_t;

  // Arctangent of 2^-i, rounded to the nearest unit.
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd210828714;
      5'd1:  v = 32'd124459457;
      5'd2:  v = 32'd65760959;
      5'd3:  v = 32'd33381290;
      5'd4:  v = 32'd16755422;
      5'd5:  v = 32'd8385879;
      5'd6:  v = 32'd4193963;
      5'd7:  v = 32'd2097109;
      5'd8:  v = 32'd1048571;
      5'd9:  v = 32'd524287;
      5'd10: v = 32'd262144;
      5'd11: v = 32'd131072;
      5'd12: v = 32'd65536;
      5'd13: v = 32'd32768;
      5'd14: v = 32'd16384;
      5'd15: v = 32'd8192;
      5'd16: v = 32'd4096;
      5'd17: v = 32'd2048;
      5'd18: v = 32'd1024;
      5'd19: v = 32'd512;
      5'd20: v = 32'd256;
      5'd21: v = 32'd128;
      5'd22: v = 32'd64;
      5'd23: v = 32'd32;
      5'd24: v = 32'd16;
      5'd25: v = 32'd8;
      5'd26: v = 32'd4;
      5'd27: v = 32'd2;
      5'd28: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/ddo_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
module ddo_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [33:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic        busy;
  logic [5:0]  cnt;
  logic [33:0] rem;
  logic [63:0] quo;
  logic [33:0] dsr;
  logic [34:0] trial;
  logic [34:0] diffv;

  assign trial    = {rem, quo[63]};
  assign diffv    = trial - {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        if (!diffv[34]) begin
          rem <= diffv[33:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= trial[33:0];
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/ddo_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, unsigned operands.
module ddo_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [95:0] prod
);

  logic        busy;
  logic [4:0]  cnt;
  logic [64:0] hi;
  logic [31:0] lo;
  logic [63:0] mcand;
  logic [64:0] addv;

  assign addv = hi + (lo[0] ? {1'b0, mcand} : 65'd0);
  assign prod = {hi[63:0], lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        hi    <= '0;
        lo    <= b;
        mcand <= a;
      end else if (busy) begin
        hi  <= {1'b0, addv[64:1]};
        lo  <= {addv[0], lo[31:1]};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/ddo_cordic.sv
// Rotation-mode CORDIC with remainder reduction by 2*pi and a fold by pi.
module ddo_cordic #(
  parameter int unsigned STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [34:0] angle,
  output logic               done,
  output ddo_pkg::trig_t     result
);

  localparam int unsigned IW = $clog2(STEPS);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_RED  = 2'd1;
  localparam logic [1:0] C_FOLD = 2'd2;
  localparam logic [1:0] C_ITER = 2'd3;

  logic [1:0]         state;
  logic [34:0]        mag;
  logic               neg_in;
  logic               flip;
  logic [IW-1:0]      idx;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [31:0] z;
  logic signed [34:0] r0;
  logic signed [34:0] r1;
  logic signed [34:0] r2;
  logic               flip_next;
  logic signed [31:0] xs;
  logic signed [31:0] ys;
  logic signed [31:0] at;

  always_comb begin
    r0 = neg_in ? -$signed(mag) : $signed(mag);
    r1 = r0;
    if (r1 > $signed({3'b0, ddo_pkg::ANG_PI})) begin
      r1 = r1 - $signed({3'b0, ddo_pkg::ANG_TWO_PI});
    end
    if (r1 < -$signed({3'b0, ddo_pkg::ANG_PI})) begin
      r1 = r1 + $signed({3'b0, ddo_pkg::ANG_TWO_PI});
    end
    r2        = r1;
    flip_next = 1'b0;
    if (r1 > $signed({3'b0, ddo_pkg::ANG_HALF_PI})) begin
      r2        = r1 - $signed({3'b0, ddo_pkg::ANG_PI});
      flip_next = 1'b1;
    end else if (r1 < -$signed({3'b0, ddo_pkg::ANG_HALF_PI})) begin
      r2        = r1 + $signed({3'b0, ddo_pkg::ANG_PI});
      flip_next = 1'b1;
    end
  end

  assign xs = y >>> idx;
  assign ys = x >>> idx;
  assign at = $signed(ddo_pkg::atan_lut(5'(idx)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            neg_in <= angle[34];
            mag    <= angle[34] ? 35'(-angle) : 35'(angle);
            state  <= C_RED;
          end
        end
        C_RED: begin
          if (mag >= {3'b0, ddo_pkg::ANG_TWO_PI}) begin
            mag <= mag - {3'b0, ddo_pkg::ANG_TWO_PI};
          end else begin
            state <= C_FOLD;
          end
        end
        C_FOLD: begin
          z     <= r2[31:0];
          x     <= $signed(ddo_pkg::CORDIC_GAIN);
          y     <= '0;
          flip  <= flip_next;
          idx   <= '0;
          state <= C_ITER;
        end
        C_ITER: begin
          if (!z[31]) begin
            x <= x - xs;
            y <= y + ys;
            z <= z - at;
          end else begin
            x <= x + xs;
            y <= y - ys;
            z <= z + at;
          end
          idx <= idx + 1'b1;
          if (idx == IW'(STEPS - 1)) begin
            state <= C_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  assign result.cos_v = flip ? -x : x;
  assign result.sin_v = flip ? -y : y;

endmodule

### hw/rtl/differential_drive_odometry_top.sv
// Differential-drive arc odometry in fixed point.
// Input words arrive on in_valid/in_stall with an opcode: an update carries
// an absolute heading and cumulative wheel totals, a set-pose word loads the
// position and heading. Each input word gives exactly one result word on
// out_valid/out_stall: position, heading and the wheel rotation estimate.
// The block works on one word at a time and holds in_stall high while busy.
// A set-pose word goes straight to the final state, which loads its result.
// An update spends its time in the bit-per-cycle divider, the shift-add
// multiplier and the CORDIC unit (range reduction plus CORDIC_STEPS
// rotations); an arc adds a half-angle CORDIC, a chord multiply and divide,
// and a zero wheel base skips the estimate divide. The next word is taken
// the cycle after a result is loaded.
// The result sits in an output register; a new word is taken while it waits,
// and the sequencer holds its finished result until the receiver stops
// stalling. Reset (synchronous, rst high) clears the pose and wheel totals
// and loads the default wheel base and small-angle threshold. The user must
// write registers over the APB port only while idle; unenforced by the block.
module differential_drive_odometry_top #(
  parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic signed [31:0] heading_in,
  input  logic signed [31:0] left_total,
  input  logic signed [31:0] right_total,
  input  logic signed [31:0] pose_x,
  input  logic signed [31:0] pose_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] x_out,
  output logic signed [31:0] y_out,
  output logic signed [31:0] heading_out,
  output logic signed [31:0] rotation_estimate
);

  `include "differential_drive_odometry_top_macros.svh"

  // Sequencer states. Each GO state launches the shared unit and each W
  // state waits for its done pulse.
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_WRAP    = 5'd1;
  localparam logic [4:0] S_EST_GO  = 5'd2;
  localparam logic [4:0] S_EST_W   = 5'd3;
  localparam logic [4:0] S_HALF_GO = 5'd4;
  localparam logic [4:0] S_HALF_W  = 5'd5;
  localparam logic [4:0] S_CHM_GO  = 5'd6;
  localparam logic [4:0] S_CHM_W   = 5'd7;
  localparam logic [4:0] S_CHD_GO  = 5'd8;
  localparam logic [4:0] S_CHD_W   = 5'd9;
  localparam logic [4:0] S_TRIG_GO = 5'd10;
  localparam logic [4:0] S_TRIG_W  = 5'd11;
  localparam logic [4:0] S_MX_GO   = 5'd12;
  localparam logic [4:0] S_MX_W    = 5'd13;
  localparam logic [4:0] S_MY_GO   = 5'd14;
  localparam logic [4:0] S_MY_W    = 5'd15;
  localparam logic [4:0] S_FIN     = 5'd16;

  logic [4:0]  state;

  logic [31:0] wheel_base;
  logic [29:0] small_angle_threshold;

  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading_now;
  logic signed [31:0] left_prev;
  logic signed [31:0] right_prev;

  // Working registers of the word in flight.
  logic [31:0] hin;
  logic [32:0] dt_raw;
  logic [33:0] dt;
  logic [33:0] dt_mag;
  logic [32:0] half;
  logic [33:0] sum;
  logic [33:0] diff;
  logic        straight;
  logic [31:0] hs;
  logic        chord_neg;
  logic [63:0] chord_mag;
  logic [31:0] c_r;
  logic [31:0] s_r;
  logic [31:0] est;

  logic        in_acc;
  logic        cfg_wr;
  logic [32:0] dl;
  logic [32:0] dr;
  logic [33:0] dt_ext;
  logic [33:0] dt_rabs;
  logic [33:0] dt_w;
  logic [33:0] dt_wabs;
  logic [33:0] sum_mag;
  logic [33:0] diff_mag;
  logic [63:0] m_mag;
  logic        m_neg;
  logic [34:0] ang_arc;

  logic        div_start;
  logic [63:0] div_dividend;
  logic [33:0] div_divisor;
  logic        div_done;
  logic [63:0] div_q;
  logic        mul_start;
  logic [63:0] mul_a;
  logic [31:0] mul_b;
  logic        mul_done;
  logic [95:0] mul_prod;
  logic        cor_start;
  logic [34:0] cor_angle;
  logic        cor_done;
  ddo_pkg::trig_t cres;

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  // pos + floor(+/-mag / 2^(28 or 29)), saturated to 32 bits.
  function automatic logic [31:0] add_sat(input logic [31:0] p, input logic [95:0] mag,
                                          input logic neg, input logic sh29);
    logic [96:0] sp;
    logic [96:0] shv;
    logic [96:0] tot;
    logic [31:0] res;
    sp  = neg ? -{1'b0, mag} : {1'b0, mag};
    shv = sh29 ? {{29{sp[96]}}, sp[96:29]} : {{28{sp[96]}}, sp[96:28]};
    tot = shv + {{65{p[31]}}, p};
    if (!tot[96] && (tot[95:31] != '0)) begin
      res = 32'h7fff_ffff;
    end else if (tot[96] && !(&tot[95:31])) begin
      res = 32'h8000_0000;
    end else begin
      res = tot[31:0];
    end
    return res;
  endfunction

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == ddo_pkg::REG_THRESHOLD) ? {2'b0, small_angle_threshold}
                                                       : wheel_base;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Wheel deltas against the stored totals.
  assign dl = {left_total[31], left_total} - {left_prev[31], left_prev};
  assign dr = {right_total[31], right_total} - {right_prev[31], right_prev};

  // Heading change wrapped once toward [-pi, pi] by a single 2*pi step.
  always_comb begin
    dt_ext  = {dt_raw[32], dt_raw};
    dt_rabs = dt_raw[32] ? -dt_ext : dt_ext;
    dt_w    = dt_ext;
    if (dt_rabs > {2'b0, ddo_pkg::ANG_PI}) begin
      dt_w = dt_raw[32] ? dt_ext + {2'b0, ddo_pkg::ANG_TWO_PI}
                        : dt_ext - {2'b0, ddo_pkg::ANG_TWO_PI};
    end
    dt_wabs = dt_w[33] ? -dt_w : dt_w;
  end

  assign sum_mag  = sum[33] ? -sum : sum;
  assign diff_mag = diff[33] ? -diff : diff;
  assign m_mag    = straight ? {30'b0, sum_mag} : chord_mag;
  assign m_neg    = straight ? sum[33] : chord_neg;
  assign ang_arc  = {{3{hin[31]}}, hin} - {{2{half[32]}}, half};

  // Operand selection for the shared units.
  assign div_start    = (state == S_EST_GO) || (state == S_CHD_GO);
  assign div_dividend = (state == S_EST_GO) ? {2'b0, diff_mag, 28'b0} : mul_prod[63:0];
  assign div_divisor  = (state == S_EST_GO) ? {2'b0, wheel_base} : dt_mag;

  assign mul_start = (state == S_CHM_GO) || (state == S_MX_GO) || (state == S_MY_GO);
  assign mul_a     = (state == S_CHM_GO) ? {30'b0, sum_mag} : m_mag;
  always_comb begin
    case (state)
      S_CHM_GO: mul_b = abs32(hs);
      S_MX_GO:  mul_b = abs32(c_r);
      default:  mul_b = abs32(s_r);
    endcase
  end

  assign cor_start = (state == S_HALF_GO) || (state == S_TRIG_GO);
  always_comb begin
    if (state == S_HALF_GO) begin
      cor_angle = {{2{half[32]}}, half};
    end else if (straight) begin
      cor_angle = {{3{hin[31]}}, hin};
    end else begin
      cor_angle = ang_arc;
    end
  end

  ddo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  ddo_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ddo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cor_start),
    .angle  ($signed(cor_angle)),
    .done   (cor_done),
    .result (cres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= S_IDLE;
      out_valid             <= 1'b0;
      wheel_base            <= 32'd32768;
      small_angle_threshold <= 30'd26844;
      pos_x                 <= '0;
      pos_y                 <= '0;
      heading_now           <= '0;
      left_prev             <= '0;
      right_prev            <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          ddo_pkg::REG_WHEEL_BASE: wheel_base            <= pwdata;
          ddo_pkg::REG_THRESHOLD:  small_angle_threshold <= pwdata[29:0];
          default: ;
        endcase
      end

      // A word taken by the receiver empties the output register unless the
      // sequencer refills it in the same cycle.
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            hin <= heading_in;
            if (opcode) begin
              pos_x       <= pose_x;
              pos_y       <= pose_y;
              heading_now <= heading_in;
              est         <= '0;
              state       <= S_FIN;
            end else begin
              dt_raw      <= {heading_in[31], heading_in} - {heading_now[31], heading_now};
              sum         <= {dl[32], dl} + {dr[32], dr};
              diff        <= {dr[32], dr} - {dl[32], dl};
              left_prev   <= left_total;
              right_prev  <= right_total;
              heading_now <= heading_in;
              state       <= S_WRAP;
            end
          end
        end
        S_WRAP: begin
          dt       <= dt_w;
          dt_mag   <= dt_wabs;
          half     <= dt_w[33:1];
          straight <= (dt_wabs < {4'b0, small_angle_threshold}) || (dt_w == '0);
          if (wheel_base == '0) begin
            // Zero wheel base saturates toward the sign of the difference.
            if (diff == '0) begin
              est <= '0;
            end else begin
              est <= diff[33] ? 32'h8000_0000 : 32'h7fff_ffff;
            end
            state <= ((dt_wabs < {4'b0, small_angle_threshold}) || (dt_w == '0))
                     ? S_TRIG_GO : S_HALF_GO;
          end else begin
            state <= S_EST_GO;
          end
        end
        S_EST_GO: state <= S_EST_W;
        S_EST_W: begin
          if (div_done) begin
            if (diff[33]) begin
              est <= (div_q > 64'h8000_0000) ? 32'h8000_0000 : -div_q[31:0];
            end else begin
              est <= (div_q > 64'h7fff_ffff) ? 32'h7fff_ffff : div_q[31:0];
            end
            state <= straight ? S_TRIG_GO : S_HALF_GO;
          end
        end
        S_HALF_GO: state <= S_HALF_W;
        S_HALF_W: begin
          if (cor_done) begin
            hs    <= cres.sin_v;
            state <= S_CHM_GO;
          end
        end
        S_CHM_GO: state <= S_CHM_W;
        S_CHM_W: begin
          if (mul_done) begin
            state <= S_CHD_GO;
          end
        end
        S_CHD_GO: state <= S_CHD_W;
        S_CHD_W: begin
          if (div_done) begin
            // Chord is truncated toward zero: sign applied to the magnitude.
            chord_mag <= div_q;
            chord_neg <= sum[33] ^ hs[31] ^ dt[33];
            state     <= S_TRIG_GO;
          end
        end
        S_TRIG_GO: state <= S_TRIG_W;
        S_TRIG_W: begin
          if (cor_done) begin
            c_r   <= cres.cos_v;
            s_r   <= cres.sin_v;
            state <= S_MX_GO;
          end
        end
        S_MX_GO: state <= S_MX_W;
        S_MX_W: begin
          if (mul_done) begin
            pos_x <= add_sat(pos_x, mul_prod, m_neg ^ c_r[31], straight);
            state <= S_MY_GO;
          end
        end
        S_MY_GO: state <= S_MY_W;
        S_MY_W: begin
          if (mul_done) begin
            pos_y <= add_sat(pos_y, mul_prod, m_neg ^ s_r[31], straight);
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            x_out             <= pos_x;
            y_out             <= pos_y;
            heading_out       <= heading_now;
            rotation_estimate <= est;
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DDO_ASSERT_IMPL(a_div_done_waited, div_done, (state == S_EST_W) || (state == S_CHD_W),
                   "divider finished outside a divider wait state")
  `DDO_ASSERT_IMPL(a_cordic_done_waited, cor_done,
                   (state == S_HALF_W) || (state == S_TRIG_W),
                   "CORDIC finished outside a CORDIC wait state")
  `DDO_ASSERT_IMPL(a_mul_done_waited, mul_done,
                   (state == S_CHM_W) || (state == S_MX_W) || (state == S_MY_W),
                   "multiplier finished outside a multiplier wait state")
  `DDO_ASSERT_NEXT(a_result_loaded, (state == S_FIN) && (!out_valid || !out_stall),
                   out_valid && (state == S_IDLE),
                   "finished result was not loaded into the output register")

endmodule

### verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Angle constants widened so that the pose arithmetic can run in 64 bits.
  localparam longint PI_A      = longint'(ddo_pkg::ANG_PI);
  localparam longint TWO_PI_A  = longint'(ddo_pkg::ANG_TWO_PI);
  localparam longint HALF_PI_A = longint'(ddo_pkg::ANG_HALF_PI);
  localparam longint GAIN_A    = longint'(ddo_pkg::CORDIC_GAIN);
  localparam int     STEPS     = ddo_pkg::CORDIC_STEPS_DEF;
  localparam longint I32_MAX   = 64'sd2147483647;
  localparam longint I32_MIN   = -64'sd2147483648;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam int     DRAIN_CYCLES = 400;

  localparam logic OP_UPDATE   = 1'b0;
  localparam logic OP_SET_POSE = 1'b1;

  // Arctangent of 2^-i in angle units, nearest unit.
  localparam longint ARCTAN [0:29] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
    4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};

  typedef struct {
    logic               op;
    logic signed [31:0] hdg;
    logic signed [31:0] left;
    logic signed [31:0] right;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } odo_word_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] hdg;
    logic signed [31:0] rot;
  } pose_word_t;

  typedef struct {
    odo_word_t  w;
    bit         typed;
    pose_word_t want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid, in_stall;
  logic opcode;
  logic signed [31:0] heading_in, left_total, right_total, pose_x, pose_y;
  logic out_valid, out_stall;
  logic signed [31:0] x_out, y_out, heading_out, rotation_estimate;

  differential_drive_odometry_top dut (.*);

  // Predictor state: the pose, the wheel totals and the two registers.
  longint m_x, m_y, m_hdg, m_left, m_right;
  longint m_base, m_thresh;

  pose_word_t pending_poses[$];
  int  mismatches;
  int  words_sent;
  int  words_seen;
  int  sender_idle_pct;
  int  receiver_stall_pct;
  logic hold_receiver;
  longint cycles;

  function automatic longint clip32(input longint v);
    if (v > I32_MAX) return I32_MAX;
    if (v < I32_MIN) return I32_MIN;
    return v;
  endfunction

  // Sine and cosine in Q28 by rotation-mode CORDIC after range reduction.
  task automatic sincos(input longint ang, output longint c, output longint s);
    longint r, x, y, z, t;
    bit flip;
    r = ang % TWO_PI_A;
    flip = 1'b0;
    if (r > PI_A) r -= TWO_PI_A;
    if (r < -PI_A) r += TWO_PI_A;
    if (r > HALF_PI_A) begin
      r -= PI_A;
      flip = 1'b1;
    end else if (r < -HALF_PI_A) begin
      r += PI_A;
      flip = 1'b1;
    end
    x = GAIN_A;
    y = 0;
    z = r;
    for (int i = 0; i < STEPS && i < 30; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= ARCTAN[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += ARCTAN[i];
      end
      x = t;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic reset_pose_model();
    m_base = 32768;
    m_thresh = 26844;
    m_x = 0; m_y = 0; m_hdg = 0; m_left = 0; m_right = 0;
  endtask

  // Advances the pose by one word and returns the pose that it reports.
  task automatic advance_pose(input odo_word_t w, output pose_word_t r);
    longint hin, est, lt, rt, dl, dr, diff, sum, dt, adt;
    longint c, s, dx, dy, half, hc, hs, chord;
    hin = longint'(w.hdg);
    est = 0;
    if (w.op == OP_SET_POSE) begin
      m_x = longint'(w.px);
      m_y = longint'(w.py);
      m_hdg = hin;
    end else begin
      lt = longint'(w.left);
      rt = longint'(w.right);
      dl = lt - m_left;
      dr = rt - m_right;
      diff = dr - dl;
      sum = dl + dr;
      dt = hin - m_hdg;
      if (m_base == 0) est = diff > 0 ? I32_MAX : (diff < 0 ? I32_MIN : 0);
      else est = clip32((diff * (64'sd1 <<< 28)) / m_base);
      m_left = lt;
      m_right = rt;
      m_hdg = hin;
      // The wrap into [-pi,pi] is applied once only.
      adt = dt < 0 ? -dt : dt;
      if (adt > PI_A) dt = dt > 0 ? dt - TWO_PI_A : dt + TWO_PI_A;
      adt = dt < 0 ? -dt : dt;
      if (adt < m_thresh || dt == 0) begin
        sincos(hin, c, s);
        dx = (sum * c) >>> 29;
        dy = (sum * s) >>> 29;
      end else begin
        half = dt >>> 1;
        sincos(half, hc, hs);
        chord = (sum * hs) / dt;
        sincos(hin - half, c, s);
        dx = (chord * c) >>> 28;
        dy = (chord * s) >>> 28;
      end
      m_x = clip32(m_x + dx);
      m_y = clip32(m_y + dy);
    end
    r.x = m_x[31:0];
    r.y = m_y[31:0];
    r.hdg = m_hdg[31:0];
    r.rot = est[31:0];
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: stalls at random, or solidly while a hold-off is running.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_receiver) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Result checker: every accepted result word is matched against the oldest
  // predicted pose, one field at a time.
  always @(posedge clk) begin
    pose_word_t e;
    if (!rst && out_valid && !out_stall) begin
      words_seen++;
      if (pending_poses.size() == 0) begin
        $error("result word with no prediction waiting");
        mismatches++;
      end else begin
        e = pending_poses.pop_front();
        if (x_out !== e.x) begin
          $error("x_out expected %0d got %0d", e.x, x_out);
          mismatches++;
        end
        if (y_out !== e.y) begin
          $error("y_out expected %0d got %0d", e.y, y_out);
          mismatches++;
        end
        if (heading_out !== e.hdg) begin
          $error("heading_out expected %0d got %0d", e.hdg, heading_out);
          mismatches++;
        end
        if (rotation_estimate !== e.rot) begin
          $error("rotation_estimate expected %0d got %0d", e.rot, rotation_estimate);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Offers one word, idling beforehand at the current rate, and predicts its
  // result once the block has taken it. The valid stays high straight into
  // the next word when no idle cycle falls between them.
  task automatic offer_word(input odo_word_t w, input bit typed, input pose_word_t want);
    pose_word_t p;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= w.op;
    heading_in <= w.hdg;
    left_total <= w.left;
    right_total <= w.right;
    pose_x <= w.px;
    pose_y <= w.py;
    do @(posedge clk); while (in_stall);
    advance_pose(w, p);
    pending_poses.push_back(typed ? want : p);
    words_sent++;
  endtask

  // Waits for every predicted result, then lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write over APB: setup phase, access phase, then idle.
  task automatic write_reg(input int idx, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(idx * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == 0) m_base = longint'(val);
    else m_thresh = longint'(val & 32'h3FFF_FFFF);
    @(posedge clk);
  endtask

  function automatic odo_word_t mk_word(input logic op, input logic [31:0] h,
                                        input logic [31:0] l, input logic [31:0] r,
                                        input logic [31:0] x, input logic [31:0] y);
    odo_word_t w;
    w.op = op; w.hdg = h; w.left = l; w.right = r; w.px = x; w.py = y;
    return w;
  endfunction

  // Random word shaped like real motion most of the time: small steps in the
  // wheel totals and heading, with set-pose words and wild jumps mixed in.
  function automatic odo_word_t random_word();
    odo_word_t w;
    int pick;
    w = mk_word(OP_UPDATE, $urandom, $urandom, $urandom, $urandom, $urandom);
    pick = $urandom_range(99);
    if (pick < 10) begin
      w.op = OP_SET_POSE;
    end else if (pick < 75) begin
      w.left = 32'(m_left + $signed($urandom_range(0, 1 << 20)) - (1 << 19));
      w.right = 32'(m_right + $signed($urandom_range(0, 1 << 20)) - (1 << 19));
      case ($urandom_range(3))
        0: w.hdg = m_hdg[31:0];
        1: w.hdg = 32'(m_hdg + $signed($urandom_range(0, 60000)) - 30000);
        2: w.hdg = 32'(m_hdg + $signed($urandom_range(0, 1 << 28)) - (1 << 27));
        default: ;
      endcase
    end else if (pick < 85) begin
      w.left = m_left[31:0];
      w.right = m_right[31:0];
      if ($urandom_range(1)) w.hdg = m_hdg[31:0];
    end
    return w;
  endfunction

  stim_row_t rows[$];

  function automatic void add_row(input odo_word_t w, input bit typed,
                                  input pose_word_t want);
    stim_row_t r;
    r.w = w;
    r.typed = typed;
    r.want = want;
    rows.push_back(r);
  endfunction

  function automatic pose_word_t pose_of(input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] h, input logic [31:0] e);
    pose_word_t p;
    p.x = x; p.y = y; p.hdg = h; p.rot = e;
    return p;
  endfunction

  localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
  localparam logic [31:0] MINN = 32'h8000_0000;

  initial begin
    pose_word_t none;
    logic [31:0] base_tab [0:7];
    logic [31:0] thr_tab [0:7];
    none = pose_of(0, 0, 0, 0);
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; opcode = OP_UPDATE;
    heading_in = '0; left_total = '0; right_total = '0; pose_x = '0; pose_y = '0;
    hold_receiver = 1'b0;
    cycles = 0;
    mismatches = 0; words_sent = 0; words_seen = 0;
    sender_idle_pct = 0; receiver_stall_pct = 0;
    reset_pose_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. Rows whose result is obvious carry it typed in; the
    // others go to the predictor.
    add_row(mk_word(OP_UPDATE, 0, 0, 0, 0, 0), 1'b1, none);
    add_row(mk_word(OP_SET_POSE, MAXP, 0, 0, MAXP, MAXP), 1'b1,
            pose_of(MAXP, MAXP, MAXP, 0));
    add_row(mk_word(OP_SET_POSE, MINN, MAXP, MINN, MINN, MINN), 1'b1,
            pose_of(MINN, MINN, MINN, 0));
    // Wheel totals at opposite extremes: the estimate saturates both ways.
    add_row(mk_word(OP_UPDATE, MINN, MINN, MAXP, 0, 0), 1'b0, none);
    add_row(mk_word(OP_UPDATE, MINN, MAXP, MINN, 0, 0), 1'b0, none);
    add_row(mk_word(OP_SET_POSE, 0, 0, 0, 0, 0), 1'b1, none);
    // Straight runs forward and backward at the same heading.
    add_row(mk_word(OP_UPDATE, 0, 32'h7FFF_0000, 32'h7FFF_0000, 0, 0), 1'b0, none);
    add_row(mk_word(OP_UPDATE, 0, 32'h0001_0000, 32'h0003_0000, 0, 0), 1'b0, none);
    // Small turns just under and exactly at the threshold, then a real arc.
    add_row(mk_word(OP_UPDATE, 26843, 32'h0002_0000, 32'h0004_0000, 0, 0), 1'b0, none);
    add_row(mk_word(OP_UPDATE, 26843 + 26844, 32'h0003_0000, 32'h0005_0000, 0, 0),
            1'b0, none);
    add_row(mk_word(OP_UPDATE, 32'd421657428, 32'h0004_0000, 32'h0008_0000, 0, 0),
            1'b0, none);
    // Heading around +pi and -pi, and a jump that the single wrap cannot fix.
    add_row(mk_word(OP_UPDATE, 32'd843314857, 32'h0005_0000, 32'h0009_0000, 0, 0),
            1'b0, none);
    add_row(mk_word(OP_UPDATE, -32'sd843314857, 32'h0006_0000, 32'h0009_8000, 0, 0),
            1'b0, none);
    add_row(mk_word(OP_SET_POSE, MINN, 0, 0, 32'h0010_0000, MINN), 1'b0, none);
    add_row(mk_word(OP_UPDATE, MAXP, 32'h0016_0000, 32'h0019_0000, 0, 0), 1'b0, none);
    add_row(mk_word(OP_UPDATE, MINN, 32'h0026_0000, 32'h0020_0000, 0, 0), 1'b0, none);
    // Position pushed against both saturation limits.
    add_row(mk_word(OP_SET_POSE, 0, 0, 0, 32'h7FFF_FF00, MINN), 1'b0, none);
    add_row(mk_word(OP_UPDATE, 0, 32'h4026_0000, 32'h4026_0000, 0, 0), 1'b0, none);
    add_row(mk_word(OP_SET_POSE, MAXP, 0, 0, 32'h8000_0100, 32'h7FFF_FF00), 1'b0, none);
    add_row(mk_word(OP_UPDATE, 32'd421657428, MINN, MINN, 0, 0), 1'b0, none);
    add_row(mk_word(OP_UPDATE, 32'd421657428, MINN, MINN, 0, 0), 1'b0, none);
    foreach (rows[i]) offer_word(rows[i].w, rows[i].typed, rows[i].want);
    drain();

    // Threshold zero with no heading change, and a zero wheel base, directed.
    write_reg(1, 0);
    write_reg(0, 0);
    offer_word(mk_word(OP_UPDATE, m_hdg[31:0], 32'(m_left + 70000), 32'(m_right + 9),
                       0, 0), 1'b0, none);
    offer_word(mk_word(OP_UPDATE, m_hdg[31:0], 32'(m_left + 9), 32'(m_right + 70000),
                       0, 0), 1'b0, none);
    offer_word(mk_word(OP_UPDATE, m_hdg[31:0], m_left[31:0], m_right[31:0], 0, 0),
               1'b0, none);
    drain();

    base_tab = '{32'd32768, 32'hFFFF_FFFF, 32'd1, 32'd0,
                 32'd65536, $urandom, 32'd32768, $urandom_range(1, 32'h0010_0000)};
    thr_tab  = '{32'd26844, 32'h3FFF_FFFF, 32'd0, 32'd0,
                 32'd1000, $urandom_range(0, 1 << 24), 32'd26844, $urandom};

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(0, base_tab[ph]);
      write_reg(1, thr_tab[ph]);
      case (ph % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 73; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 73; end
        default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
      endcase
      if (ph == 2) begin
        // Long hold-off on the result side while words keep coming, so the
        // output register and the sequencer fill up and the input stalls.
        hold_receiver <= 1'b1;
        fork
          begin
            repeat (3000) @(posedge clk);
            hold_receiver <= 1'b0;
          end
        join_none
      end
      repeat (55) offer_word(random_word(), 1'b0, none);
      // The sender pauses here until every result has come back.
      drain();
    end

    $display("Covered %0d input words and %0d results over 8 register settings,",
             words_sent, words_seen);
    $display("with set-pose, straight, arc, wrap and saturation cases mixed in.");
    if (mismatches == 0 && pending_poses.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
